>>> sv/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types, constants and helper functions of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// Hue in 1/64 degree: one turn and one 60-degree sector
	localparam int HUE_W      = 16;
	localparam int HUE_TURN   = 23040;
	localparam int HUE_SECTOR = 3840;

	// Q14 unit after clamping: 0..16384
	localparam int UNIT_W  = 15;
	localparam int ONE_Q14 = 16384;

	// Wrapped hue 0..23039 and distance to the sector end 0..3840
	localparam int HU_W   = 15;
	localparam int DIST_W = 12;

	// Full-scale term 16384 * 3840 and the widths of the products
	localparam int KFULL   = ONE_Q14 * HUE_SECTOR;
	localparam int K_W     = 26;
	localparam int SU_W    = UNIT_W + DIST_W;
	localparam int VM_W    = 29;
	localparam int T_W     = 40;
	localparam int CH_W    = 9;

	typedef logic [UNIT_W-1:0] unit_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [K_W-1:0]    kterm_t;
	typedef logic [VM_W-1:0]   vmterm_t;
	typedef logic [T_W-1:0]    tterm_t;
	typedef logic [CH_W-1:0]   chan_t;
	typedef logic [2:0]        sector_t;

	// Sectors, named by the channel that gets chroma, then the one that gets x
	localparam sector_t SECT_R_G = 3'd0;
	localparam sector_t SECT_G_R = 3'd1;
	localparam sector_t SECT_G_B = 3'd2;
	localparam sector_t SECT_B_G = 3'd3;
	localparam sector_t SECT_B_R = 3'd4;
	localparam sector_t SECT_R_B = 3'd5;

	// Clamp a signed Q2.14 number to the unit interval
	function automatic unit_t clamp_unit(input logic signed [HUE_W-1:0] q);
		unit_t res;
		if (q[HUE_W-1]) begin
			res = '0;
		end else if (q > HUE_W'(ONE_Q14)) begin
			res = UNIT_W'(ONE_Q14);
		end else begin
			res = q[UNIT_W-1:0];
		end
		return res;
	endfunction

	// Saturate a channel to 8 bits
	function automatic logic [7:0] sat_chan(input chan_t c);
		logic [7:0] res;
		if (c[CH_W-1]) begin
			res = 8'hFF;
		end else begin
			res = c[7:0];
		end
		return res;
	endfunction

endpackage

>>> sv/hsv2rgb_front.sv
// ----------------------------------------------------------------------------
// hsv2rgb_front
// Stage 1 wraps hue and clamps s and v; stage 2 finds the sector and the
// distance of the hue to the end of the chroma ramp.
// ----------------------------------------------------------------------------
module hsv2rgb_front
	import hsv2rgb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [HUE_W-1:0] hue,
	input  logic signed [HUE_W-1:0] saturation,
	input  logic signed [HUE_W-1:0] brightness,
	output logic                    out_valid,
	input  logic                    out_ready,
	output sector_t                 sector,
	output dist_t                   ramp,
	output unit_t                   sat,
	output unit_t                   val
);

	localparam logic signed [HUE_W:0] TURN1 = (HUE_W+1)'(HUE_TURN);
	localparam logic signed [HUE_W:0] TURN2 = (HUE_W+1)'(2 * HUE_TURN);

	logic                valid_s1, valid_s2;
	logic                adv_s1, adv_s2;
	logic signed [HUE_W:0] hx, hw;
	logic [HU_W-1:0]     hu_s1;
	unit_t               sat_s1, val_s1;
	sector_t             sec_c, sector_s2;
	logic [HU_W-1:0]     base_c, off_c;
	dist_t               dist_c, dist_s2;
	unit_t               sat_s2, val_s2;

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	// Hue wrap: at most one constant added or subtracted
	always_comb begin
		hx = {hue[HUE_W-1], hue};
		if (hx < -TURN1) begin
			hw = hx + TURN2;
		end else if (hx < 0) begin
			hw = hx + TURN1;
		end else if (hx >= TURN1) begin
			hw = hx - TURN1;
		end else begin
			hw = hx;
		end
	end

	// Sector search over five thresholds
	always_comb begin
		if (hu_s1 >= HU_W'(5 * HUE_SECTOR)) begin
			sec_c  = SECT_R_B;
			base_c = HU_W'(5 * HUE_SECTOR);
		end else if (hu_s1 >= HU_W'(4 * HUE_SECTOR)) begin
			sec_c  = SECT_B_R;
			base_c = HU_W'(4 * HUE_SECTOR);
		end else if (hu_s1 >= HU_W'(3 * HUE_SECTOR)) begin
			sec_c  = SECT_B_G;
			base_c = HU_W'(3 * HUE_SECTOR);
		end else if (hu_s1 >= HU_W'(2 * HUE_SECTOR)) begin
			sec_c  = SECT_G_B;
			base_c = HU_W'(2 * HUE_SECTOR);
		end else if (hu_s1 >= HU_W'(HUE_SECTOR)) begin
			sec_c  = SECT_G_R;
			base_c = HU_W'(HUE_SECTOR);
		end else begin
			sec_c  = SECT_R_G;
			base_c = '0;
		end
		off_c = hu_s1 - base_c;
		// x = c*(3840-dist)/3840
		if (sec_c[0]) begin
			dist_c = off_c[DIST_W-1:0];
		end else begin
			dist_c = DIST_W'(HUE_SECTOR) - off_c[DIST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			hu_s1  <= hw[HU_W-1:0];
			sat_s1 <= clamp_unit(saturation);
			val_s1 <= clamp_unit(brightness);
		end
		if (adv_s2 && valid_s1) begin
			sector_s2 <= sec_c;
			dist_s2   <= dist_c;
			sat_s2    <= sat_s1;
			val_s2    <= val_s1;
		end
	end

	assign out_valid = valid_s2;
	assign sector    = sector_s2;
	assign ramp      = dist_s2;
	assign sat       = sat_s2;
	assign val       = val_s2;

endmodule

>>> sv/hsv2rgb_mult.sv
// ----------------------------------------------------------------------------
// hsv2rgb_mult
// Stage 3 forms s*ramp and v*(1-s); stage 4 forms v*(K - s*ramp) and the
// flat channel levels scaled by 255.
// ----------------------------------------------------------------------------
module hsv2rgb_mult
	import hsv2rgb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  sector_t sector,
	input  dist_t   ramp,
	input  unit_t   sat,
	input  unit_t   val,
	output logic    out_valid,
	input  logic    out_ready,
	output sector_t out_sector,
	output tterm_t  xterm,
	output chan_t   zero_chan,
	output chan_t   full_chan
);

	logic                 valid_s3, valid_s4;
	logic                 adv_s3, adv_s4;
	logic [SU_W-1:0]      su_c;
	kterm_t               k_s3;
	vmterm_t              vm_s3;
	unit_t                val_s3;
	sector_t              sector_s3, sector_s4;
	logic [VM_W+7:0]      vm255_c;
	logic [UNIT_W+7:0]    v255_c;
	tterm_t               t_s4;
	chan_t                zero_s4, full_s4;

	assign adv_s4   = !valid_s4 || out_ready;
	assign adv_s3   = !valid_s3 || adv_s4;
	assign in_ready = adv_s3;

	assign su_c    = SU_W'(sat) * SU_W'(ramp);
	assign vm255_c = (VM_W+8)'(vm_s3) * (VM_W+8)'(255);
	assign v255_c  = (UNIT_W+8)'(val_s3) * (UNIT_W+8)'(255);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s3) begin
				valid_s3 <= in_valid;
			end
			if (adv_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && in_valid) begin
			k_s3      <= K_W'(SU_W'(KFULL) - su_c);
			vm_s3     <= VM_W'(VM_W'(val) * VM_W'(UNIT_W'(ONE_Q14) - sat));
			val_s3    <= val;
			sector_s3 <= sector;
		end
		if (adv_s4 && valid_s3) begin
			t_s4      <= T_W'(val_s3) * T_W'(k_s3);
			zero_s4   <= vm255_c[VM_W+7 -: CH_W];
			full_s4   <= v255_c[UNIT_W+7 -: CH_W];
			sector_s4 <= sector_s3;
		end
	end

	assign out_valid  = valid_s4;
	assign out_sector = sector_s4;
	assign xterm      = t_s4;
	assign zero_chan  = zero_s4;
	assign full_chan  = full_s4;

endmodule

>>> sv/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSV to 8-bit RGB conversion for a pixel stream, exact fixed point.
// ----------------------------------------------------------------------------
// Pipeline: five register stages, s1 and s2 in the front, s3 and s4 in the
//   multiplier, s5 at the output; each accepted transaction passes them in order.
// Throughput: one transaction per cycle while out_ready does not hold the output;
//   every stage has its own valid bit and advances when empty or when its successor advances, so bubbles fill in.
// Reset: arst_n clears all valid bits asynchronously; data registers keep
//   whatever they hold and are ignored until refilled.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
	import hsv2rgb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [HUE_W-1:0] hue,
	input  logic signed [HUE_W-1:0] saturation,
	input  logic signed [HUE_W-1:0] brightness,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [7:0]              red,
	output logic [7:0]              green,
	output logic [7:0]              blue
);

	// Per channel, with D = 2^28 * 3840:
	//   chroma channel : floor(255*(c+m)/D) = floor(v*255 / 2^14)
	//   zero channel   : floor(255*m/D)     = floor(v*(1-s)*255 / 2^28)
	//   x channel      : floor(255*(x+m)/D) = floor(17*v*(K - s*dist) / 2^36)
	// where K = 16384*3840 and dist = 3840 - g. Only the last truncation rounds.

	logic    f_valid, f_ready;
	sector_t f_sector;
	dist_t   f_dist;
	unit_t   f_sat, f_val;

	logic    m_valid, m_ready;
	sector_t m_sector;
	tterm_t  m_xterm;
	chan_t   m_zero, m_full;

	logic                 valid_s5, adv_s5;
	logic [T_W+4:0]       x17_c;
	logic [7:0]           xc_c, zc_c, fc_c;
	logic [7:0]           red_s5, green_s5, blue_s5;

	hsv2rgb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.out_valid  (f_valid),
		.out_ready  (f_ready),
		.sector     (f_sector),
		.ramp       (f_dist),
		.sat        (f_sat),
		.val        (f_val)
	);

	hsv2rgb_mult u_mult (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (f_valid),
		.in_ready   (f_ready),
		.sector     (f_sector),
		.ramp       (f_dist),
		.sat        (f_sat),
		.val        (f_val),
		.out_valid  (m_valid),
		.out_ready  (m_ready),
		.out_sector (m_sector),
		.xterm      (m_xterm),
		.zero_chan  (m_zero),
		.full_chan  (m_full)
	);

	// Output stage doubles as the result register: advance when empty or taken
	assign adv_s5  = !valid_s5 || out_ready;
	assign m_ready = adv_s5;

	// 17*t as t + 16*t, then drop the 2^36 denominator
	assign x17_c = (T_W+5)'(m_xterm) + ((T_W+5)'(m_xterm) << 4);
	assign xc_c  = sat_chan(x17_c[T_W+4 -: CH_W] > CH_W'(255) ? CH_W'(256)
		: x17_c[36 +: CH_W]);
	assign zc_c  = sat_chan(m_zero);
	assign fc_c  = sat_chan(m_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv_s5) begin
			valid_s5 <= m_valid;
		end
	end

	// Route chroma, x and the flat level into the channels by sector
	always_ff @(posedge clk) begin
		if (adv_s5 && m_valid) begin
			unique case (m_sector)
				SECT_R_G: begin
					red_s5   <= fc_c;
					green_s5 <= xc_c;
					blue_s5  <= zc_c;
				end
				SECT_G_R: begin
					red_s5   <= xc_c;
					green_s5 <= fc_c;
					blue_s5  <= zc_c;
				end
				SECT_G_B: begin
					red_s5   <= zc_c;
					green_s5 <= fc_c;
					blue_s5  <= xc_c;
				end
				SECT_B_G: begin
					red_s5   <= zc_c;
					green_s5 <= xc_c;
					blue_s5  <= fc_c;
				end
				SECT_B_R: begin
					red_s5   <= xc_c;
					green_s5 <= zc_c;
					blue_s5  <= fc_c;
				end
				default: begin
					red_s5   <= fc_c;
					green_s5 <= zc_c;
					blue_s5  <= xc_c;
				end
			endcase
		end
	end

	assign out_valid = valid_s5;
	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;

endmodule

>>> tb/sv/hsv_to_rgb_converter_test.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_test
// Self-checking bench for the HSV to RGB converter: drives hue, saturation
// and brightness transactions, predicts each RGB triple in exact fixed point
// and compares every result against the oldest prediction in order, under
// several sender and receiver idling patterns and a long output stall.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_test;
	import hsv2rgb_pkg::*;

	// Run limits and stall lengths in clock cycles, and item counts per phase
	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 200;
	localparam int DRAIN_CYCLES  = 16;
	localparam int PHASE_ITEMS   = 240;
	localparam int FILL_ITEMS    = 40;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    in_valid   = 1'b0;
	logic                    in_ready;
	logic signed [HUE_W-1:0] hue        = '0;
	logic signed [HUE_W-1:0] saturation = '0;
	logic signed [HUE_W-1:0] brightness = '0;
	logic                    out_valid;
	logic                    out_ready  = 1'b0;
	logic [7:0]              red;
	logic [7:0]              green;
	logic [7:0]              blue;

	// Expected RGB triples, oldest first
	rgb_t rgb_q[$];
	int   error_cnt = 0;
	int   cycle_cnt = 0;

	// Idling knobs: percent of cycles the sender idles and the receiver stalls
	int   idle_pct  = 0;
	int   stall_pct = 0;

	// Long output hold-off: the test bumps hold_req, the receiver acks it
	int   hold_req  = 0;
	int   hold_ack  = 0;
	int   hold_left = 0;

	hsv_to_rgb_converter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.hue       (hue),
		.saturation(saturation),
		.brightness(brightness),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Clamp a signed Q2.14 number to 0..1.0
	function automatic longint unsigned clamp_q14(input logic signed [HUE_W-1:0] q);
		longint unsigned res;
		if (q < 0) begin
			res = 0;
		end else if (q > ONE_Q14) begin
			res = ONE_Q14;
		end else begin
			res = longint'(q);
		end
		return res;
	endfunction

	// Scale a numerator over 2^28 * 3840 to 0..255, truncating, then clamp
	function automatic logic [7:0] scale_channel(input longint unsigned num);
		longint unsigned denom;
		longint unsigned ch;
		denom = (64'd1 << 28) * HUE_SECTOR;
		ch = (num * 255) / denom;
		if (ch > 255) begin
			ch = 255;
		end
		return ch[7:0];
	endfunction

	// Exact RGB triple of one HSV transaction
	function automatic rgb_t predict_rgb(input logic signed [HUE_W-1:0] h_in,
			input logic signed [HUE_W-1:0] s_in, input logic signed [HUE_W-1:0] v_in);
		int              h;
		longint unsigned s, v, hu, f, g, vs, cn, xn, mn, rn, gn, bn;
		sector_t         sect;
		rgb_t            res;
		h = h_in;
		s = clamp_q14(s_in);
		v = clamp_q14(v_in);
		// Wrap the hue into one turn
		while (h < 0) begin
			h += HUE_TURN;
		end
		while (h >= HUE_TURN) begin
			h -= HUE_TURN;
		end
		hu   = longint'(h);
		sect = sector_t'(hu / HUE_SECTOR);
		f    = hu - (hu / HUE_SECTOR) * HUE_SECTOR;
		// Odd sectors ramp down, even sectors ramp up
		g    = sect[0] ? HUE_SECTOR - f : f;
		vs   = v * s;
		cn   = vs * HUE_SECTOR;
		xn   = vs * g;
		mn   = v * (ONE_Q14 - s) * HUE_SECTOR;
		case (sect)
			SECT_R_G: begin rn = cn; gn = xn; bn = 0;  end
			SECT_G_R: begin rn = xn; gn = cn; bn = 0;  end
			SECT_G_B: begin rn = 0;  gn = cn; bn = xn; end
			SECT_B_G: begin rn = 0;  gn = xn; bn = cn; end
			SECT_B_R: begin rn = xn; gn = 0;  bn = cn; end
			default: begin  rn = cn; gn = 0;  bn = xn; end
		endcase
		res.red   = scale_channel(rn + mn);
		res.green = scale_channel(gn + mn);
		res.blue  = scale_channel(bn + mn);
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Sender: present one transaction, idle at random first
	// ------------------------------------------------------------------------
	// Called in the time step of a rising edge. in_ready is sampled at the
	// falling edge, where it holds the value that the next rising edge sees.
	task automatic send_hsv(input logic signed [HUE_W-1:0] h,
			input logic signed [HUE_W-1:0] s, input logic signed [HUE_W-1:0] v);
		bit ready_seen;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(0, 99) < idle_pct);
		end
		in_valid   <= 1'b1;
		hue        <= h;
		saturation <= s;
		brightness <= v;
		do begin
			@(negedge clk);
			ready_seen = in_ready;
			@(posedge clk);
		end while (!ready_seen);
		rgb_q.push_back(predict_rgb(h, s, v));
	endtask

	// Drop valid and hold until every expected triple has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (rgb_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// One random transaction: mostly in-range colors, some noise and edges
	task automatic send_random_hsv();
		logic signed [HUE_W-1:0] h, s, v;
		int                      kind;
		kind = $urandom_range(0, 9);
		h = HUE_W'($urandom);
		s = HUE_W'($urandom_range(0, ONE_Q14));
		v = HUE_W'($urandom_range(0, ONE_Q14));
		case (kind)
			7: begin
				// Full raw range on every field
				s = HUE_W'($urandom);
				v = HUE_W'($urandom);
			end
			8: begin
				// Saturation and brightness at or past the clamp points
				s = ($urandom_range(0, 1) != 0) ? HUE_W'(ONE_Q14 + $urandom_range(0, 16383))
					: HUE_W'(-$urandom_range(1, 32768));
				v = ($urandom_range(0, 1) != 0) ? HUE_W'(ONE_Q14 + $urandom_range(0, 16383))
					: HUE_W'(-$urandom_range(1, 32768));
			end
			9: begin
				// Hue at a sector border, possibly a turn away; sums past 16 bits wrap
				h = HUE_W'(int'($urandom_range(0, 5)) * HUE_SECTOR
					+ int'($urandom_range(0, 2)) - 1
					+ (int'($urandom_range(0, 2)) - 1) * HUE_TURN);
			end
			default: begin
			end
		endcase
		send_hsv(h, s, v);
	endtask

	// ------------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off on request
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Checker: compare each output transaction with the oldest expectation
	// ------------------------------------------------------------------------
	// Outputs and out_ready are stable at the falling edge, so a handshake
	// seen here is the one the next rising edge completes.
	always @(negedge clk) begin : check_rgb
		rgb_t want;
		if (arst_n && out_valid && out_ready) begin
			if (rgb_q.size() == 0) begin
				$error("unexpected result: red %0d green %0d blue %0d", red, green, blue);
				error_cnt++;
			end else begin
				want = rgb_q.pop_front();
				if (red !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, red);
					error_cnt++;
				end
				if (green !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, green);
					error_cnt++;
				end
				if (blue !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, blue);
					error_cnt++;
				end
			end
		end
	end

	// Watchdog: end a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Corners: sector starts and ends, hue wrap in both directions, and the
	// clamp points of saturation and brightness
	task automatic test_directed_corners();
		idle_pct  = 0;
		stall_pct = 0;
		for (int k = 0; k < 6; k++) begin
			send_hsv(HUE_W'(k * HUE_SECTOR), 16'sd16384, 16'sd16384);
		end
		send_hsv(16'sd3839, 16'sd16384, 16'sd16384);
		send_hsv(16'sd23039, 16'sd16384, 16'sd16384);
		// Hue outside one turn: two turns added, then one subtracted, added, subtracted, added
		send_hsv(-16'sd32768, 16'sd16384, 16'sd16384);
		send_hsv(16'sd32767, 16'sd16384, 16'sd16384);
		send_hsv(-16'sd1, 16'sd16384, 16'sd16384);
		send_hsv(16'sd23040, 16'sd16384, 16'sd16384);
		send_hsv(-16'sd23040, 16'sd16384, 16'sd16384);
		// Saturation below zero, zero, above one and at the top of the range
		send_hsv(16'sd1920, -16'sd32768, 16'sd16384);
		send_hsv(16'sd1920, -16'sd1, 16'sd16384);
		send_hsv(16'sd1920, 16'sd0, 16'sd16384);
		send_hsv(16'sd1920, 16'sd16385, 16'sd16384);
		send_hsv(16'sd1920, 16'sd32767, 16'sd16384);
		// Brightness below zero, zero and at the top, then two plain colors
		send_hsv(16'sd5000, 16'sd16384, -16'sd32768);
		send_hsv(16'sd5000, 16'sd16384, 16'sd0);
		send_hsv(16'sd5000, 16'sd16384, 16'sd32767);
		send_hsv(16'sd5000, 16'sd8192, 16'sd16383);
		send_hsv(16'sd9600, 16'sd12345, 16'sd9876);
		drain_results();
	endtask

	// Random stream under one idling pattern
	task automatic test_random_stream(input int sender_idle, input int receiver_stall);
		idle_pct  = sender_idle;
		stall_pct = receiver_stall;
		repeat (PHASE_ITEMS) begin
			send_random_hsv();
		end
		drain_results();
	endtask

	// Hold the output off while the sender keeps pushing, so the pipeline
	// fills and in_ready drops; then let it run out
	task automatic test_backpressure_fill();
		idle_pct  = 0;
		stall_pct = 0;
		hold_req  = hold_req + 1;
		repeat (FILL_ITEMS) begin
			send_random_hsv();
		end
		drain_results();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_random_stream(0, 0);
		test_random_stream(52, 0);
		test_random_stream(0, 52);
		test_random_stream(16, 16);
		test_backpressure_fill();

		// Let any stray output show up before deciding
		stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_cnt == 0 && rgb_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> files.f
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_front.sv
sv/hsv2rgb_mult.sv
sv/hsv_to_rgb_converter.sv
tb/sv/hsv_to_rgb_converter_test.sv
